FILE: src/rbrk4_pkg.sv
// shared types, codes and saturating arithmetic for the rk4 rigid body stepper
package rbrk4_pkg;

	localparam int FRAC_BITS = 32;

	localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [62:0] ONE_Q = 63'd1 << FRAC_BITS;

	// commands
	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_STEP    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// modes
	localparam logic [1:0] MODE_FREE   = 2'd0;
	localparam logic [1:0] MODE_PRESC  = 2'd1;
	localparam logic [1:0] MODE_SPRING = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_MODE    = 3'd0;
	localparam logic [2:0] CFG_SETVEL  = 3'd1;
	localparam logic [2:0] CFG_STIFF   = 3'd2;
	localparam logic [2:0] CFG_DAMP    = 3'd3;
	localparam logic [2:0] CFG_IMASS   = 3'd4;
	localparam logic [2:0] CFG_IINERT  = 3'd5;
	localparam logic [2:0] CFG_RESTX   = 3'd6;
	localparam logic [2:0] CFG_RESTY   = 3'd7;

	// register file addresses
	localparam logic [5:0] RF_Y    = 6'd0;
	localparam logic [5:0] RF_T    = 6'd6;
	localparam logic [5:0] RF_K1   = 6'd12;
	localparam logic [5:0] RF_K2   = 6'd18;
	localparam logic [5:0] RF_K3   = 6'd24;
	localparam logic [5:0] RF_TMP0 = 6'd30;
	localparam logic [5:0] RF_TMP1 = 6'd31;

	// operands outside the register file
	localparam logic [5:0] SRC_ZERO = 6'h20;
	localparam logic [5:0] SRC_AFX  = 6'h21;
	localparam logic [5:0] SRC_AFY  = 6'h22;
	localparam logic [5:0] SRC_ATQ  = 6'h23;
	localparam logic [5:0] SRC_SFX  = 6'h24;
	localparam logic [5:0] SRC_SFY  = 6'h25;
	localparam logic [5:0] SRC_STQ  = 6'h26;
	localparam logic [5:0] SRC_KST  = 6'h27;
	localparam logic [5:0] SRC_CDM  = 6'h28;
	localparam logic [5:0] SRC_IMS  = 6'h29;
	localparam logic [5:0] SRC_IIN  = 6'h2A;
	localparam logic [5:0] SRC_RSX  = 6'h2B;
	localparam logic [5:0] SRC_RSY  = 6'h2C;
	localparam logic [5:0] SRC_SVL  = 6'h2D;
	localparam logic [5:0] SRC_DT   = 6'h2E;
	localparam logic [5:0] SRC_PX   = 6'h2F;
	localparam logic [5:0] SRC_PY   = 6'h30;
	localparam logic [5:0] SRC_FX   = 6'h31;
	localparam logic [5:0] SRC_FY   = 6'h32;

	localparam logic [5:0] DST_SFX  = 6'h24;
	localparam logic [5:0] DST_SFY  = 6'h25;
	localparam logic [5:0] DST_STQ  = 6'h26;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_HADD,
		OP_MUL,
		OP_DIV6
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] sa;
		logic [5:0] sb;
		logic [5:0] dst;
	} uop_t;

	typedef struct packed {
		logic [63:0] val;
		logic        sat;
	} alu_res_t;

	function automatic alu_res_t sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		alu_res_t r;
		s = {a[63], a} + {b[63], b};
		r.sat = s[64] != s[63];
		r.val = r.sat ? (a[63] ? MIN64 : MAX64) : s[63:0];
		return r;
	endfunction

	function automatic alu_res_t sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		alu_res_t r;
		s = {a[63], a} - {b[63], b};
		r.sat = s[64] != s[63];
		r.val = r.sat ? (a[63] ? MIN64 : MAX64) : s[63:0];
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] x);
		return x[63] ? 64'd0 - x : x;
	endfunction

	// round half away from zero on the magnitude, then saturate
	function automatic alu_res_t mul_round(input logic [127:0] acc, input logic neg);
		logic [127:0] p2;
		logic [63:0]  q;
		logic [63:0]  lim;
		logic         over;
		alu_res_t     r;
		p2   = acc + (128'd1 << (FRAC_BITS - 1));
		over = |(p2 >> (FRAC_BITS + 64));
		q    = p2[FRAC_BITS +: 64];
		lim  = neg ? MIN64 : MAX64;
		r.sat = over || (q > lim);
		if (r.sat) begin
			r.val = neg ? MIN64 : MAX64;
		end else begin
			r.val = neg ? 64'd0 - q : q;
		end
		return r;
	endfunction

endpackage

FILE: src/rigid_body_rk4_step.sv
// planar rigid body stepper: microcoded sequencer around one shared multiply and add unit
//
// Input channel (in_valid/in_ready) takes one request at a time: cmd 0 adds a boundary
// force sample and its torque to the accumulators, cmd 1 runs one fourth-order
// Runge-Kutta step, cmd 2 reloads the rest position and clears motion. cmd 3 is dropped.
// Only a step request produces a result on the output channel (out_valid/out_ready).
// The block is busy while a request runs, longest for a step in spring-damper mode.
// The step time is set by the 32x32 partial-product multiplier (42 products per step,
// 50 with the spring), which also serves the divide by six as a reciprocal multiply in
// the final combine.
// A finished result sits in the output register; samples are still taken meanwhile,
// and a following step holds before its combine phase until that result is taken.
// Configuration writes go through cfg_we/cfg_addr/cfg_data; the user must make them
// only while idle, as the block itself does not enforce this. Reset clears the force
// accumulators and resets the configuration and control registers; a clearing pass
// then loads the body state from the rest position (zero after reset) with in_ready low.
module rigid_body_rk4_step import rbrk4_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [63:0] point_x,
	input  logic signed [63:0] point_y,
	input  logic signed [63:0] force_x,
	input  logic signed [63:0] force_y,
	input  logic [62:0]        time_step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] out_pos_x,
	output logic signed [63:0] out_pos_y,
	output logic signed [63:0] out_vel_x,
	output logic signed [63:0] out_vel_y,
	output logic signed [63:0] out_angle,
	output logic signed [63:0] out_ang_vel,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [63:0]        cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EX,
		S_MUL,
		S_WB,
		S_DONE
	} state_t;

	// microprogram addresses
	localparam logic [5:0] PC_SETV = 6'd0;
	localparam logic [5:0] PC_COPY = 6'd1;
	localparam logic [5:0] PC_D0   = 6'd2;
	localparam logic [5:0] PC_D1   = 6'd3;
	localparam logic [5:0] PC_D2   = 6'd4;
	localparam logic [5:0] PC_D3   = 6'd5;
	localparam logic [5:0] PC_D4   = 6'd6;
	localparam logic [5:0] PC_D5   = 6'd7;
	localparam logic [5:0] PC_D6   = 6'd8;
	localparam logic [5:0] PC_D7   = 6'd9;
	localparam logic [5:0] PC_D8   = 6'd10;
	localparam logic [5:0] PC_D9   = 6'd11;
	localparam logic [5:0] PC_D10  = 6'd12;
	localparam logic [5:0] PC_D11  = 6'd13;
	localparam logic [5:0] PC_D12  = 6'd14;
	localparam logic [5:0] PC_D13  = 6'd15;
	localparam logic [5:0] PC_D14  = 6'd16;
	localparam logic [5:0] PC_TUPD = 6'd17;
	localparam logic [5:0] PC_C0   = 6'd18;
	localparam logic [5:0] PC_C1   = 6'd19;
	localparam logic [5:0] PC_C2   = 6'd20;
	localparam logic [5:0] PC_C3   = 6'd21;
	localparam logic [5:0] PC_C4   = 6'd22;
	localparam logic [5:0] PC_C5   = 6'd23;
	localparam logic [5:0] PC_S0   = 6'd24;
	localparam logic [5:0] PC_S1   = 6'd25;
	localparam logic [5:0] PC_S2   = 6'd26;
	localparam logic [5:0] PC_S3   = 6'd27;
	localparam logic [5:0] PC_S4   = 6'd28;
	localparam logic [5:0] PC_S5   = 6'd29;
	localparam logic [5:0] PC_S6   = 6'd30;
	localparam logic [5:0] PC_S7   = 6'd31;
	localparam logic [5:0] PC_RST  = 6'd32;

	localparam logic [2:0] LAST_LANE  = 3'd5;
	localparam logic [1:0] LAST_STAGE = 2'd3;

	// ceil(2^65 / 3): floor(n / 3) = (n * RECIP3) >> 65 for n below 2^63
	localparam logic [63:0] RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

	state_t      state_q;
	logic [5:0]  pc_q;
	logic [2:0]  lane_q;
	logic [1:0]  stg_q;
	logic [1:0]  cmd_q;
	logic        sat_q;
	logic        sample_sat_q;

	// configuration
	logic [1:0]  mode_q;
	logic [63:0] setvel_q;
	logic [62:0] stiff_q;
	logic [62:0] damp_q;
	logic [62:0] imass_q;
	logic [62:0] iinert_q;
	logic [63:0] restx_q;
	logic [63:0] resty_q;

	// force accumulators and applied load
	logic [63:0] sfx_q, sfy_q, stq_q;
	logic [63:0] afx_q, afy_q, atq_q;

	// latched request payload
	logic [63:0] px_q, py_q, fx_q, fy_q;
	logic [62:0] dt_q;

	// register file
	logic [63:0] rf_mem [32];
	logic [63:0] rd_a_q, rd_b_q;

	// multiplier datapath, also used for the divide by six
	logic [63:0]  ma_q, mb_q;
	logic         mneg_q;
	logic [127:0] macc_q;
	logic [1:0]   mcnt_q;
	logic         dneg_q;

	uop_t        uop;
	logic [5:0]  lane_off;
	logic [5:0]  kb;
	logic [5:0]  nxt_pc;
	logic [2:0]  nxt_lane;
	logic [1:0]  nxt_stg;
	logic        last;
	logic [63:0] a_val, b_val;
	alu_res_t    alu_r, wb_r, wr_res;
	logic        wr_en;
	logic        is_spring;
	logic        hold_out;
	logic [63:0] pp;
	logic [6:0]  pp_sh;

	assign in_ready  = state_q == S_IDLE;
	assign is_spring = mode_q == MODE_SPRING;
	assign lane_off  = {3'b000, lane_q};
	// combine writes the output register, so it waits for the previous result to leave
	assign hold_out  = (pc_q == PC_C0) && (lane_q == 3'd0) && out_valid;

	always_comb begin
		unique case (stg_q)
			2'd0: kb = RF_K1;
			2'd1: kb = RF_K2;
			2'd2: kb = RF_K3;
			default: kb = RF_T;
		endcase
	end

	function automatic logic [63:0] spec_val(input logic [5:0] c);
		logic [63:0] v;
		case (c)
			SRC_AFX: v = afx_q;
			SRC_AFY: v = afy_q;
			SRC_ATQ: v = atq_q;
			SRC_SFX: v = sfx_q;
			SRC_SFY: v = sfy_q;
			SRC_STQ: v = stq_q;
			SRC_KST: v = {1'b0, stiff_q};
			SRC_CDM: v = {1'b0, damp_q};
			SRC_IMS: v = {1'b0, imass_q};
			SRC_IIN: v = {1'b0, iinert_q};
			SRC_RSX: v = restx_q;
			SRC_RSY: v = resty_q;
			SRC_SVL: v = setvel_q;
			SRC_DT:  v = {1'b0, dt_q};
			SRC_PX:  v = px_q;
			SRC_PY:  v = py_q;
			SRC_FX:  v = fx_q;
			SRC_FY:  v = fy_q;
			default: v = 64'd0;
		endcase
		return v;
	endfunction

	// microcode decode
	always_comb begin
		uop = '{op: OP_ADD, sa: SRC_ZERO, sb: SRC_ZERO, dst: RF_TMP0};
		unique case (pc_q)
			PC_SETV: uop = '{OP_ADD, (mode_q == MODE_PRESC) ? SRC_SVL : RF_Y + 6'd2, SRC_ZERO,
				RF_Y + 6'd2};
			PC_COPY: uop = '{OP_ADD, RF_Y + lane_off, SRC_ZERO, RF_T + lane_off};
			PC_D0: begin
				if (is_spring) begin
					uop = '{OP_SUB, RF_T, SRC_RSX, RF_TMP0};
				end else begin
					uop = '{OP_ADD, SRC_AFX, SRC_ZERO, RF_TMP0};
				end
			end
			PC_D1:  uop = '{OP_MUL, SRC_KST, RF_TMP0, RF_TMP0};
			PC_D2:  uop = '{OP_MUL, SRC_CDM, RF_T + 6'd2, RF_TMP1};
			PC_D3:  uop = '{OP_SUB, SRC_ZERO, RF_TMP0, RF_TMP0};
			PC_D4:  uop = '{OP_SUB, RF_TMP0, RF_TMP1, RF_TMP0};
			PC_D5:  uop = '{OP_ADD, SRC_AFX, RF_TMP0, RF_TMP0};
			PC_D6:  uop = '{OP_MUL, RF_TMP0, SRC_IMS, RF_TMP0};
			// k writes go in an order that lets the last stage reuse the t slots
			PC_D7:  uop = '{OP_MUL, SRC_DT, RF_T + 6'd2, kb};
			PC_D8:  uop = '{OP_MUL, SRC_DT, RF_TMP0, kb + 6'd2};
			PC_D9:  uop = '{OP_MUL, SRC_DT, RF_T + 6'd3, kb + 6'd1};
			PC_D10: uop = '{OP_MUL, SRC_DT, RF_T + 6'd5, kb + 6'd4};
			PC_D11: uop = '{OP_MUL, SRC_AFY, SRC_IMS, RF_TMP0};
			PC_D12: uop = '{OP_MUL, SRC_DT, RF_TMP0, kb + 6'd3};
			PC_D13: uop = '{OP_MUL, SRC_ATQ, SRC_IIN, RF_TMP0};
			PC_D14: uop = '{OP_MUL, SRC_DT, RF_TMP0, kb + 6'd5};
			PC_TUPD: uop = '{(stg_q == 2'd2) ? OP_ADD : OP_HADD, RF_Y + lane_off, kb + lane_off,
				RF_T + lane_off};
			PC_C0: uop = '{OP_ADD, RF_K2 + lane_off, RF_K3 + lane_off, RF_TMP0};
			PC_C1: uop = '{OP_ADD, RF_TMP0, RF_TMP0, RF_TMP0};
			PC_C2: uop = '{OP_ADD, RF_K1 + lane_off, RF_TMP0, RF_TMP0};
			PC_C3: uop = '{OP_ADD, RF_TMP0, RF_T + lane_off, RF_TMP0};
			PC_C4: uop = '{OP_DIV6, RF_TMP0, SRC_ZERO, RF_TMP0};
			PC_C5: uop = '{OP_ADD, RF_Y + lane_off, RF_TMP0, RF_Y + lane_off};
			PC_S0: uop = '{OP_SUB, SRC_PX, RF_Y, RF_TMP0};
			PC_S1: uop = '{OP_SUB, SRC_PY, RF_Y + 6'd1, RF_TMP1};
			PC_S2: uop = '{OP_ADD, SRC_SFX, SRC_FX, DST_SFX};
			PC_S3: uop = '{OP_ADD, SRC_SFY, SRC_FY, DST_SFY};
			PC_S4: uop = '{OP_MUL, RF_TMP0, SRC_FY, RF_TMP0};
			PC_S5: uop = '{OP_MUL, RF_TMP1, SRC_FX, RF_TMP1};
			PC_S6: uop = '{OP_SUB, RF_TMP0, RF_TMP1, RF_TMP0};
			PC_S7: uop = '{OP_ADD, SRC_STQ, RF_TMP0, DST_STQ};
			PC_RST: uop = '{OP_ADD, (lane_q == 3'd0) ? SRC_RSX :
				((lane_q == 3'd1) ? SRC_RSY : SRC_ZERO), SRC_ZERO, RF_Y + lane_off};
			default: ;
		endcase
	end

	// sequencing
	always_comb begin
		nxt_pc   = pc_q + 6'd1;
		nxt_lane = lane_q;
		nxt_stg  = stg_q;
		last     = 1'b0;
		unique case (pc_q)
			PC_COPY, PC_TUPD, PC_C5, PC_RST: begin
				if (lane_q == LAST_LANE) begin
					nxt_lane = 3'd0;
					case (pc_q)
						PC_COPY: nxt_pc = PC_D0;
						PC_TUPD: begin
							nxt_pc  = PC_D0;
							nxt_stg = stg_q + 2'd1;
						end
						default: last = 1'b1;
					endcase
				end else begin
					nxt_lane = lane_q + 3'd1;
					case (pc_q)
						PC_C5: nxt_pc = PC_C0;
						default: nxt_pc = pc_q;
					endcase
				end
			end
			PC_D0: nxt_pc = is_spring ? PC_D1 : PC_D6;
			PC_D14: nxt_pc = (stg_q == LAST_STAGE) ? PC_C0 : PC_TUPD;
			PC_S7: last = 1'b1;
			default: ;
		endcase
	end

	// operands and the add unit
	always_comb begin
		a_val = uop.sa[5] ? spec_val(uop.sa) : rd_a_q;
		b_val = uop.sb[5] ? spec_val(uop.sb) : rd_b_q;
		case (uop.op)
			OP_SUB:  alu_r = sat_sub(a_val, b_val);
			OP_HADD: alu_r = sat_add(a_val, {b_val[63], b_val[63:1]});
			default: alu_r = sat_add(a_val, b_val);
		endcase
		if (uop.op == OP_DIV6) begin
			wb_r.val = dneg_q ? 64'd0 - {1'b0, macc_q[127:65]} : {1'b0, macc_q[127:65]};
			wb_r.sat = 1'b0;
		end else begin
			wb_r = mul_round(macc_q, mneg_q);
		end
		wr_en  = ((state_q == S_EX) && (uop.op != OP_MUL) && (uop.op != OP_DIV6)) ||
			(state_q == S_WB);
		wr_res = (state_q == S_WB) ? wb_r : alu_r;
	end

	// one partial product per cycle
	always_comb begin
		pp    = {32'd0, mcnt_q[0] ? ma_q[63:32] : ma_q[31:0]} *
			{32'd0, mcnt_q[1] ? mb_q[63:32] : mb_q[31:0]};
		pp_sh = {({1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]}), 5'b00000};
	end

	always_ff @(posedge clk) begin
		if (wr_en && !uop.dst[5]) begin
			rf_mem[uop.dst[4:0]] <= wr_res.val;
		end
		if (state_q == S_RD) begin
			rd_a_q <= rf_mem[uop.sa[4:0]];
			rd_b_q <= rf_mem[uop.sb[4:0]];
		end
	end

	// datapath and payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_q <= point_x;
			py_q <= point_y;
			fx_q <= force_x;
			fy_q <= force_y;
			dt_q <= time_step;
		end
		if (state_q == S_EX) begin
			mneg_q <= a_val[63] ^ b_val[63];
			// divide by six: halve the rounded magnitude, then multiply by the reciprocal of 3
			ma_q   <= (uop.op == OP_DIV6) ? ((mag64(a_val) + 64'd3) >> 1) : mag64(a_val);
			mb_q   <= (uop.op == OP_DIV6) ? RECIP3 : mag64(b_val);
			macc_q <= 128'd0;
			dneg_q <= a_val[63];
		end
		if (state_q == S_MUL) begin
			macc_q <= macc_q + ({64'd0, pp} << pp_sh);
		end
		if (wr_en && (pc_q == PC_C5)) begin
			case (lane_q)
				3'd0: out_pos_x   <= wr_res.val;
				3'd1: out_pos_y   <= wr_res.val;
				3'd2: out_vel_x   <= wr_res.val;
				3'd3: out_vel_y   <= wr_res.val;
				3'd4: out_angle   <= wr_res.val;
				default: out_ang_vel <= wr_res.val;
			endcase
		end
		if ((state_q == S_DONE) && (cmd_q == CMD_STEP)) begin
			saturated <= sat_q | sample_sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FREE;
			setvel_q <= 64'd0;
			stiff_q  <= 63'd0;
			damp_q   <= 63'd0;
			imass_q  <= ONE_Q;
			iinert_q <= ONE_Q;
			restx_q  <= 64'd0;
			resty_q  <= 64'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_SETVEL: setvel_q <= cfg_data;
				CFG_STIFF:  stiff_q  <= cfg_data[62:0];
				CFG_DAMP:   damp_q   <= cfg_data[62:0];
				CFG_IMASS:  imass_q  <= cfg_data[62:0];
				CFG_IINERT: iinert_q <= cfg_data[62:0];
				CFG_RESTX:  restx_q  <= cfg_data;
				default:    resty_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// body state lives in the register file, so reset runs the restart sequence
			state_q      <= S_RD;
			pc_q         <= PC_RST;
			lane_q       <= 3'd0;
			stg_q        <= 2'd0;
			cmd_q        <= CMD_RESTART;
			sat_q        <= 1'b0;
			sample_sat_q <= 1'b0;
			out_valid    <= 1'b0;
			mcnt_q       <= 2'd0;
			sfx_q        <= 64'd0;
			sfy_q        <= 64'd0;
			stq_q        <= 64'd0;
			afx_q        <= 64'd0;
			afy_q        <= 64'd0;
			atq_q        <= 64'd0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (wr_en) begin
				case (uop.dst)
					DST_SFX: sfx_q <= wr_res.val;
					DST_SFY: sfy_q <= wr_res.val;
					DST_STQ: stq_q <= wr_res.val;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q  <= cmd;
						sat_q  <= 1'b0;
						lane_q <= 3'd0;
						stg_q  <= 2'd0;
						case (cmd)
							CMD_SAMPLE: begin
								pc_q    <= PC_S0;
								state_q <= S_RD;
							end
							CMD_STEP: begin
								if (mode_q == MODE_PRESC) begin
									afy_q <= 64'd0;
									atq_q <= 64'd0;
								end else if (mode_q == MODE_SPRING) begin
									afx_q <= sfx_q;
									afy_q <= 64'd0;
									atq_q <= 64'd0;
								end else begin
									afx_q <= sfx_q;
									afy_q <= sfy_q;
									atq_q <= stq_q;
								end
								sfx_q   <= 64'd0;
								sfy_q   <= 64'd0;
								stq_q   <= 64'd0;
								pc_q    <= PC_SETV;
								state_q <= S_RD;
							end
							CMD_RESTART: begin
								sfx_q        <= 64'd0;
								sfy_q        <= 64'd0;
								stq_q        <= 64'd0;
								afx_q        <= 64'd0;
								afy_q        <= 64'd0;
								atq_q        <= 64'd0;
								sample_sat_q <= 1'b0;
								pc_q         <= PC_RST;
								state_q      <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (!hold_out) begin
						state_q <= S_EX;
					end
				end
				S_EX, S_WB: begin
					if ((state_q == S_EX) && ((uop.op == OP_MUL) || (uop.op == OP_DIV6))) begin
						mcnt_q  <= 2'd0;
						state_q <= S_MUL;
					end else begin
						sat_q   <= sat_q | wr_res.sat;
						pc_q    <= nxt_pc;
						lane_q  <= nxt_lane;
						stg_q   <= nxt_stg;
						state_q <= last ? S_DONE : S_RD;
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) begin
						state_q <= S_WB;
					end
				end
				S_DONE: begin
					case (cmd_q)
						CMD_STEP: begin
							out_valid    <= 1'b1;
							sample_sat_q <= 1'b0;
						end
						CMD_SAMPLE: sample_sat_q <= sample_sat_q | sat_q;
						default: ;
					endcase
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/rigid_body_rk4_step_tb.sv
// self-checking testbench for the rk4 rigid body stepper with its own fixed point predictor
module rigid_body_rk4_step_tb;
	import rbrk4_pkg::*;

	typedef logic signed [63:0] fix_t;

	typedef struct {
		logic [1:0] cmd;
		fix_t       px;
		fix_t       py;
		fix_t       fx;
		fix_t       fy;
		logic [62:0] dt;
		bit         known;
		bit         known_sat;
	} body_req_t;

	typedef struct {
		fix_t pos_x;
		fix_t pos_y;
		fix_t vel_x;
		fix_t vel_y;
		fix_t angle;
		fix_t ang_vel;
		logic sat;
	} body_state_t;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 800;
	localparam fix_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam fix_t QMIN = 64'sh8000_0000_0000_0000;
	localparam fix_t QONE = 64'sh1_0000_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	fix_t        point_x;
	fix_t        point_y;
	fix_t        force_x;
	fix_t        force_y;
	logic [62:0] time_step;
	logic        out_valid;
	logic        out_ready;
	fix_t        out_pos_x;
	fix_t        out_pos_y;
	fix_t        out_vel_x;
	fix_t        out_vel_y;
	fix_t        out_angle;
	fix_t        out_ang_vel;
	logic        saturated;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [63:0] cfg_data;

	rigid_body_rk4_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .point_x(point_x), .point_y(point_y),
		.force_x(force_x), .force_y(force_y), .time_step(time_step),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
		.out_vel_x(out_vel_x), .out_vel_y(out_vel_y),
		.out_angle(out_angle), .out_ang_vel(out_ang_vel),
		.saturated(saturated),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// predictor copy of registers and body state
	logic [1:0] cfg_mode;
	fix_t set_vel, k_stiff, c_damp, inv_m, inv_i, rest_x, rest_y;
	fix_t body_px, body_py, body_vx, body_vy, body_ang, body_w;
	fix_t acc_fx, acc_fy, acc_tq, load_fx, load_fy, load_tq;
	bit   sample_sat;
	bit   sat_hit;

	body_state_t expected_states[$];
	int   mismatches;
	int   idle_cycles;
	int   burst_left;

	function automatic fix_t s_add(input fix_t a, input fix_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat_hit = 1'b1;
			return a[63] ? QMIN : QMAX;
		end
		return s[63:0];
	endfunction

	function automatic fix_t s_sub(input fix_t a, input fix_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			sat_hit = 1'b1;
			return a[63] ? QMIN : QMAX;
		end
		return s[63:0];
	endfunction

	function automatic logic [63:0] abs_of(input fix_t x);
		return x[63] ? 64'd0 - x : x;
	endfunction

	// exact product, rounded half away from zero on the magnitude
	function automatic fix_t f_mul(input fix_t a, input fix_t b);
		logic         neg;
		logic [127:0] p;
		logic [63:0]  q;
		neg = a[63] ^ b[63];
		p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
		p = p + (128'd1 << 31);
		q = p[95:32];
		if (p[127:96] != 0 || q > (neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)) begin
			sat_hit = 1'b1;
			return neg ? QMIN : QMAX;
		end
		return neg ? 64'd0 - q : q;
	endfunction

	function automatic fix_t div_six(input fix_t x);
		logic [64:0] q;
		q = ({1'b0, abs_of(x)} + 65'd3) / 65'd6;
		return x[63] ? 64'd0 - q[63:0] : q[63:0];
	endfunction

	task automatic rk_stage(input fix_t s[6], input fix_t dt, output fix_t k[6]);
		fix_t fx;
		fix_t f[6];
		fx = load_fx;
		if (cfg_mode == MODE_SPRING)
			fx = s_add(fx, s_sub(s_sub(0, f_mul(k_stiff, s_sub(s[0], rest_x))),
				f_mul(c_damp, s[2])));
		f[0] = s[2];
		f[1] = s[3];
		f[2] = f_mul(fx, inv_m);
		f[3] = f_mul(load_fy, inv_m);
		f[4] = s[5];
		f[5] = f_mul(load_tq, inv_i);
		for (int i = 0; i < 6; i++)
			k[i] = f_mul(dt, f[i]);
	endtask

	task automatic advance_body(input fix_t dt, output body_state_t r);
		fix_t y[6], t[6], k1[6], k2[6], k3[6], k4[6];
		fix_t m, s;
		sat_hit = 1'b0;
		if (cfg_mode == MODE_PRESC) begin
			body_vx = set_vel;
		end else begin
			load_fx = acc_fx;
			load_fy = acc_fy;
			load_tq = acc_tq;
		end
		if (cfg_mode == MODE_PRESC || cfg_mode == MODE_SPRING) begin
			load_fy = 0;
			load_tq = 0;
		end
		acc_fx = 0;
		acc_fy = 0;
		acc_tq = 0;
		y = '{body_px, body_py, body_vx, body_vy, body_ang, body_w};
		rk_stage(y, dt, k1);
		for (int i = 0; i < 6; i++) t[i] = s_add(y[i], k1[i] >>> 1);
		rk_stage(t, dt, k2);
		for (int i = 0; i < 6; i++) t[i] = s_add(y[i], k2[i] >>> 1);
		rk_stage(t, dt, k3);
		for (int i = 0; i < 6; i++) t[i] = s_add(y[i], k3[i]);
		rk_stage(t, dt, k4);
		for (int i = 0; i < 6; i++) begin
			m = s_add(k2[i], k3[i]);
			s = s_add(s_add(k1[i], s_add(m, m)), k4[i]);
			y[i] = s_add(y[i], div_six(s));
		end
		body_px = y[0];
		body_py = y[1];
		body_vx = y[2];
		body_vy = y[3];
		body_ang = y[4];
		body_w = y[5];
		r = '{y[0], y[1], y[2], y[3], y[4], y[5], sat_hit | sample_sat};
		sample_sat = 1'b0;
	endtask

	// updates the predicted body for one accepted request, queues the step result
	task automatic predict_request(input body_req_t rq);
		fix_t rx, ry;
		body_state_t r;
		case (rq.cmd)
			CMD_SAMPLE: begin
				sat_hit = 1'b0;
				rx = s_sub(rq.px, body_px);
				ry = s_sub(rq.py, body_py);
				acc_fx = s_add(acc_fx, rq.fx);
				acc_fy = s_add(acc_fy, rq.fy);
				acc_tq = s_add(acc_tq, s_sub(f_mul(rx, rq.fy), f_mul(ry, rq.fx)));
				if (sat_hit) sample_sat = 1'b1;
			end
			CMD_RESTART: begin
				body_px = rest_x;
				body_py = rest_y;
				{body_vx, body_vy, body_ang, body_w} = '0;
				{acc_fx, acc_fy, acc_tq, load_fx, load_fy, load_tq} = '0;
				sample_sat = 1'b0;
			end
			CMD_STEP: begin
				advance_body({1'b0, rq.dt}, r);
				if (rq.known) r = '{0, 0, 0, 0, 0, 0, rq.known_sat};
				expected_states.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MODE:   cfg_mode = val[1:0];
			CFG_SETVEL: set_vel = val;
			CFG_STIFF:  k_stiff = {1'b0, val[62:0]};
			CFG_DAMP:   c_damp = {1'b0, val[62:0]};
			CFG_IMASS:  inv_m = {1'b0, val[62:0]};
			CFG_IINERT: inv_i = {1'b0, val[62:0]};
			CFG_RESTX:  rest_x = val;
			default:    rest_y = val;
		endcase
	endtask

	task automatic program_regs(input logic [63:0] v[8]);
		for (int i = 0; i < 8; i++)
			write_reg(i[2:0], v[i]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		while (expected_states.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_request(input body_req_t rq);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= rq.cmd;
		point_x <= rq.px;
		point_y <= rq.py;
		force_x <= rq.fx;
		force_y <= rq.fy;
		time_step <= rq.dt;
		do @(posedge clk); while (!in_ready);
		predict_request(rq);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 10);
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic fix_t rnd_val();
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1: case ($urandom_range(0, 3))
				0: return QMAX;
				1: return QMIN;
				2: return 0;
				default: return -1;
			endcase
			default: return $signed({$urandom, $urandom}) >>> 24;
		endcase
	endfunction

	function automatic logic [62:0] rnd_dt();
		logic [63:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) return w[62:0];
		return {31'd0, w[31:0]} >> $urandom_range(2, 10);
	endfunction

	function automatic body_req_t rnd_request(input logic [1:0] c);
		body_req_t rq;
		rq = '{c, rnd_val(), rnd_val(), rnd_val(), rnd_val(), rnd_dt(), 1'b0, 1'b0};
		return rq;
	endfunction

	task automatic random_phase(input int n, input bit mid_drain);
		int sent;
		int len;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: dropped commands, stray restarts and steps
				send_request(rnd_request(2'd3));
				send_request(rnd_request(2'($urandom_range(1, 2))));
				sent++;
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					send_request(rnd_request(CMD_RESTART));
					sent++;
				end
				len = $urandom_range(0, 8);
				repeat (len) send_request(rnd_request(CMD_SAMPLE));
				send_request(rnd_request(CMD_STEP));
				sent += len + 1;
			end
			if (mid_drain && sent > n / 2) begin
				mid_drain = 0;
				@(negedge clk);
				in_valid <= 1'b0;
				drain_results();
			end
		end
	endtask

	body_req_t directed[] = '{
		'{CMD_STEP,    0, 0, 0, 0, 63'd0, 1, 0},
		'{2'd3,        QMAX, QMIN, QMAX, QMIN, '1, 0, 0},
		'{CMD_SAMPLE,  QMAX, QMIN, QMAX, QMIN, 63'd0, 0, 0},
		'{CMD_STEP,    0, 0, 0, 0, 63'd0, 1, 1},
		'{CMD_RESTART, 0, 0, 0, 0, 63'd0, 0, 0},
		'{CMD_SAMPLE,  QONE, -QONE, 3 * QONE, -2 * QONE, 63'd0, 0, 0},
		'{CMD_SAMPLE,  -QONE, 2 * QONE, -QONE, QONE, 63'd0, 0, 0},
		'{CMD_STEP,    0, 0, 0, 0, 63'h1_0000_0000, 0, 0},
		'{CMD_STEP,    0, 0, 0, 0, '1, 0, 0},
		'{CMD_RESTART, 0, 0, 0, 0, 63'd0, 0, 0},
		'{CMD_SAMPLE,  QMIN, QMAX, -1, 1, 63'd0, 0, 0},
		'{CMD_SAMPLE,  0, 0, 0, 0, 63'd0, 0, 0},
		'{CMD_STEP,    0, 0, 0, 0, 63'h8000_0000, 0, 0},
		'{CMD_STEP,    0, 0, 0, 0, 63'd1, 0, 0},
		'{CMD_RESTART, 0, 0, 0, 0, 63'd0, 0, 0}
	};

	logic [63:0] regs[8];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_SAMPLE;
		{point_x, point_y, force_x, force_y} = '0;
		time_step = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_MODE;
		cfg_data = '0;
		cfg_mode = MODE_FREE;
		{set_vel, k_stiff, c_damp, rest_x, rest_y} = '0;
		inv_m = QONE;
		inv_i = QONE;
		{body_px, body_py, body_vx, body_vy, body_ang, body_w} = '0;
		{acc_fx, acc_fy, acc_tq, load_fx, load_fy, load_tq} = '0;
		sample_sat = 1'b0;
		mismatches = 0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_request(directed[i]);
		random_phase(150, 0);
		settle_block();

		regs = '{MODE_FREE, 0, 0, 0, 64'h8000_0000, 64'h2_0000_0000, 5 * QONE, -3 * QONE};
		program_regs(regs);
		send_request(rnd_request(CMD_RESTART));
		random_phase(200, 1);
		settle_block();

		regs = '{MODE_PRESC, rnd_val(), 0, 0, QONE, QONE, QONE, QONE};
		program_regs(regs);
		random_phase(200, 0);
		settle_block();

		regs = '{MODE_SPRING, 0, 64'h2_0000_0000, 64'h4000_0000, QONE, QONE, -2 * QONE, 0};
		program_regs(regs);
		send_request(rnd_request(CMD_RESTART));
		random_phase(200, 0);
		settle_block();

		// extremes, unused mode, top bit of the unsigned registers set
		regs = '{64'hFFFF_FFFF_FFFF_FFFF, QMIN, '1, '1, '1, '1, QMAX, QMIN};
		program_regs(regs);
		send_request(rnd_request(CMD_RESTART));
		random_phase(150, 0);
		settle_block();

		regs = '{MODE_SPRING, QMAX, QMAX, 0, 0, 0, QMIN, QMAX};
		program_regs(regs);
		send_request(rnd_request(CMD_RESTART));
		random_phase(150, 0);
		settle_block();

		regs = '{MODE_PRESC, QMAX, 0, QMAX, 0, QMAX, 0, 0};
		program_regs(regs);
		random_phase(150, 0);
		settle_block();

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// receiver stalls in runs: always ready, coin flips, or long holds
	int rdy_run = 0;
	int rdy_kind = 0;
	always @(negedge clk) begin
		if (rdy_run == 0) begin
			rdy_kind = $urandom_range(0, 3);
			rdy_run = $urandom_range(20, 300);
		end
		rdy_run--;
		case (rdy_kind)
			0, 1: out_ready <= 1'b1;
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= 1'b0;
		endcase
	end

	initial out_ready = 1'b0;

	task automatic check_field(input string name, input fix_t got, input fix_t want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		body_state_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_states.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected step result, pos_x %h", out_pos_x);
			end else begin
				e = expected_states.pop_front();
				check_field("pos_x", out_pos_x, e.pos_x);
				check_field("pos_y", out_pos_y, e.pos_y);
				check_field("vel_x", out_vel_x, e.vel_x);
				check_field("vel_y", out_vel_y, e.vel_y);
				check_field("angle", out_angle, e.angle);
				check_field("ang_vel", out_ang_vel, e.ang_vel);
				check_field("saturated", fix_t'(saturated), fix_t'(e.sat));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule
